FILE: rtl/core/can_bts_pkg.sv
// Shared types, widths and constants for the CAN bit timing search.
// Used by can_bts_div, can_bts_seq and can_bit_timing_search.
// No dependencies.
package can_bts_pkg;

   localparam int CLK_W  = 27;          // controller clock register
   localparam int HALF_W = CLK_W - 1;   // half clock, divider dividend and quotient
   localparam int BND_W  = CLK_W - 4;   // initial bound is clock / 16
   localparam int TGT_W  = 20;          // largest target rate is 1000000
   localparam int RATE_W = 23;          // reported rate
   localparam int PRE_W  = 7;
   localparam int SUM_W  = 5;
   localparam int DIVR_W = 11;          // 64 * 25 = 1600 fits
   localparam int PROD_W = PRE_W + SUM_W + 1;
   localparam int CNT_W  = 5;           // holds HALF_W
   localparam int CODE_W = 4;

   localparam int MAX_PRESCALER   = 64;
   localparam int MIN_SEGMENT_SUM = 5;
   localparam int MAX_SEGMENT_SUM = 24;
   localparam int SJW_VALUE       = 2;
   localparam int NUM_RATES       = 9;
   localparam logic [CLK_W-1:0] CLK_RESET = CLK_W'(16000000);

   localparam logic signed [5:0] TSEG1_MIN = 6'sd3;
   localparam logic signed [5:0] TSEG1_MAX = 6'sd16;
   localparam logic signed [5:0] SJW_S     = 6'(SJW_VALUE);
   localparam logic [3:0]        TSEG2_MIN = 4'd2;
   localparam logic [3:0]        TSEG2_MAX = 4'd8;

   typedef enum logic [1:0] {
      ST_OK,
      ST_BAD_CODE,
      ST_BAD_TIMING,
      ST_NOT_RESET
   } status_type;

   typedef enum logic [2:0] {
      SEQ_IDLE,
      SEQ_MUL,
      SEQ_LOAD,
      SEQ_WAIT,
      SEQ_EVAL,
      SEQ_DONE
   } seq_state_type;

   typedef struct packed {
      logic               done;
      logic [PRE_W-1:0]   pre;
      logic [SUM_W-1:0]   sum;
      logic [RATE_W-1:0]  rate;
   } search_result_type;

   function automatic logic [TGT_W-1:0] target_rate(input logic [CODE_W-1:0] code);
      logic [TGT_W-1:0] r;
      unique case (code)
         4'd0:    r = TGT_W'(1000000);
         4'd1:    r = TGT_W'(800000);
         4'd2:    r = TGT_W'(500000);
         4'd3:    r = TGT_W'(250000);
         4'd4:    r = TGT_W'(125000);
         4'd5:    r = TGT_W'(100000);
         4'd6:    r = TGT_W'(50000);
         4'd7:    r = TGT_W'(20000);
         4'd8:    r = TGT_W'(10000);
         default: r = '0;
      endcase
      return r;
   endfunction

   // sum / 3 as (sum * 11) >> 5, exact for every 5-bit sum
   function automatic logic [3:0] third(input logic [SUM_W-1:0] sum);
      logic [SUM_W+3:0] p;
      p = (SUM_W+4)'(sum) * (SUM_W+4)'(11);
      return p[SUM_W+3:5];
   endfunction

endpackage

FILE: rtl/core/can_bit_timing_search.sv
// CAN bit timing search, top level: command port, clock register and
// result formatting. Depends on can_bts_pkg and can_bts_seq.
//
// Usage: write the controller clock in Hz on csr_data with csr_valid while
// the block is idle (csr_ready is high when busy and start are low); reset
// loads 16000000. Issue a command by raising start with req_bitrate_code,
// req_sample_mode and req_controller_in_reset; it is taken at an edge
// where busy is low, and busy stays high until the result goes out.
// Each command yields one result word, shown for exactly one cycle with
// rsp_valid high; the receiver cannot stall it, so capture it then.
// An unsupported code skips the search: accepting it sets the busy and
// bad-code flags, from which the result word and rsp_valid are registered.
// A supported code runs the pair search over at most 1280 prescaler and
// segment sum pairs, paced by the bit-serial divider that produces one
// quotient bit of the 26-bit half clock per cycle; an exact match ends it early.
// Reset clears the command and result control; a search in progress is dropped.
module can_bit_timing_search (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   start,
   output logic                                   busy,
   input  logic [3:0]                             req_bitrate_code,
   input  logic                                   req_sample_mode,
   input  logic                                   req_controller_in_reset,
   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  logic [can_bts_pkg::CLK_W-1:0]          csr_data,
   output logic                                   rsp_valid,
   output logic [1:0]                             rsp_status,
   output logic [22:0]                            rsp_achieved_bitrate,
   output logic [6:0]                             rsp_prescaler,
   output logic signed [5:0]                      rsp_time_seg1,
   output logic [3:0]                             rsp_time_seg2,
   output logic [7:0]                             rsp_timing_byte0,
   output logic [7:0]                             rsp_timing_byte1,
   output logic                                   rsp_write_enable
);

   logic [can_bts_pkg::CLK_W-1:0] clk_hz_ff;
   logic busy_ff, bad_code_ff, sample_ff, in_reset_ff, rsp_valid_ff;
   logic accept, bad_code, go, emit;

   can_bts_pkg::search_result_type res;
   can_bts_pkg::status_type        status;

   logic [3:0]        t2, t2_m1;
   logic signed [5:0] t1, t1_m1;
   logic [6:0]        pre_m1;
   logic              timing_bad;

   logic [1:0]        status_ff;
   logic [22:0]       rate_ff;
   logic [6:0]        pre_ff;
   logic signed [5:0] t1_ff;
   logic [3:0]        t2_ff;
   logic [7:0]        byte0_ff, byte1_ff;
   logic              we_ff;

   assign accept   = start && !busy_ff;
   assign bad_code = req_bitrate_code > 4'(can_bts_pkg::NUM_RATES - 1);
   assign go       = accept && !bad_code;
   assign emit     = (busy_ff && bad_code_ff) || res.done;

   can_bts_seq u_seq (
      .clock  (clock),
      .reset  (reset),
      .go     (go),
      .target (can_bts_pkg::target_rate(req_bitrate_code)),
      .clk_hz (clk_hz_ff),
      .res    (res)
   );

   always_comb begin
      t2 = can_bts_pkg::third(res.sum);
      if (t2 < 4'd3) begin
         t2 = 4'd3;
      end
      t1     = $signed({1'b0, res.sum}) - $signed({2'b00, t2});
      t1_m1  = t1 - 6'sd1;
      t2_m1  = t2 - 4'd1;
      pre_m1 = res.pre - 7'd1;
      timing_bad = (t1 < can_bts_pkg::SJW_S) || (t1 < can_bts_pkg::TSEG1_MIN) ||
                   (t1 > can_bts_pkg::TSEG1_MAX) || (t2 < can_bts_pkg::TSEG2_MIN) ||
                   (t2 > can_bts_pkg::TSEG2_MAX);
      if (timing_bad) begin
         status = can_bts_pkg::ST_BAD_TIMING;
      end else if (!in_reset_ff) begin
         status = can_bts_pkg::ST_NOT_RESET;
      end else begin
         status = can_bts_pkg::ST_OK;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clk_hz_ff    <= can_bts_pkg::CLK_RESET;
         busy_ff      <= 1'b0;
         bad_code_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            clk_hz_ff <= csr_data;
         end
         if (accept) begin
            busy_ff     <= 1'b1;
            bad_code_ff <= bad_code;
         end else if (emit) begin
            busy_ff     <= 1'b0;
            bad_code_ff <= 1'b0;
         end
         rsp_valid_ff <= emit && !accept;
      end
   end

   // latch command fields and the result word
   always_ff @(posedge clock) begin
      if (accept) begin
         sample_ff   <= req_sample_mode;
         in_reset_ff <= req_controller_in_reset;
      end
      if (emit) begin
         if (bad_code_ff) begin
            status_ff <= can_bts_pkg::ST_BAD_CODE;
            rate_ff   <= '0;
            pre_ff    <= '0;
            t1_ff     <= '0;
            t2_ff     <= '0;
            byte0_ff  <= '0;
            byte1_ff  <= '0;
            we_ff     <= 1'b0;
         end else begin
            status_ff <= status;
            rate_ff   <= res.rate;
            pre_ff    <= res.pre;
            t1_ff     <= t1;
            t2_ff     <= t2;
            if (status == can_bts_pkg::ST_OK) begin
               byte0_ff <= {2'(can_bts_pkg::SJW_VALUE - 1), pre_m1[5:0]};
               byte1_ff <= {sample_ff, t2_m1[2:0], t1_m1[3:0]};
               we_ff    <= 1'b1;
            end else begin
               byte0_ff <= '0;
               byte1_ff <= '0;
               we_ff    <= 1'b0;
            end
         end
      end
   end

   assign busy                 = busy_ff;
   // hold off clock writes while busy or while a command is offered
   assign csr_ready            = !busy_ff && !start;
   assign rsp_valid            = rsp_valid_ff;
   assign rsp_status           = status_ff;
   assign rsp_achieved_bitrate = rate_ff;
   assign rsp_prescaler        = pre_ff;
   assign rsp_time_seg1        = t1_ff;
   assign rsp_time_seg2        = t2_ff;
   assign rsp_timing_byte0     = byte0_ff;
   assign rsp_timing_byte1     = byte1_ff;
   assign rsp_write_enable     = we_ff;

   a_single_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe held for more than one cycle");

   a_ok_has_prescaler: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == 2'(can_bts_pkg::ST_OK)) |-> rsp_prescaler != 7'd0)
      else $error("ok status without a prescaler");

endmodule

FILE: rtl/core/can_bts_div.sv
// Bit-serial restoring divider: one quotient bit per cycle.
// Depends on can_bts_pkg for widths.
module can_bts_div (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  logic [can_bts_pkg::HALF_W-1:0]    dividend,
   input  logic [can_bts_pkg::DIVR_W-1:0]    divisor,
   output logic                              done,
   output logic [can_bts_pkg::HALF_W-1:0]    quotient
);

   logic [can_bts_pkg::HALF_W-1:0] quo_ff, quo_in;
   logic [can_bts_pkg::DIVR_W-1:0] rem_ff, rem_in;
   logic [can_bts_pkg::CNT_W-1:0]  cnt_ff, cnt_in;
   logic                           done_ff, done_in;
   logic [can_bts_pkg::DIVR_W:0]   trial, diff;
   logic                           fits;

   always_comb begin
      trial = {rem_ff, quo_ff[can_bts_pkg::HALF_W-1]};
      diff  = trial - {1'b0, divisor};
      fits  = trial >= {1'b0, divisor};
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      done_in = 1'b0;
      if (start) begin
         quo_in = dividend;
         rem_in = '0;
         cnt_in = can_bts_pkg::CNT_W'(can_bts_pkg::HALF_W);
      end else if (cnt_ff != '0) begin
         quo_in  = {quo_ff[can_bts_pkg::HALF_W-2:0], fits};
         rem_in  = fits ? diff[can_bts_pkg::DIVR_W-1:0] : trial[can_bts_pkg::DIVR_W-1:0];
         cnt_in  = cnt_ff - 1'b1;
         done_in = (cnt_ff == can_bts_pkg::CNT_W'(1));
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

FILE: rtl/core/can_bts_seq.sv
// Search sequencer: walks prescaler and segment sum pairs, divides through
// can_bts_div and keeps the closest rate. Depends on can_bts_pkg and can_bts_div.
module can_bts_seq (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                go,
   input  logic [can_bts_pkg::TGT_W-1:0]       target,
   input  logic [can_bts_pkg::CLK_W-1:0]       clk_hz,
   output can_bts_pkg::search_result_type      res
);

   can_bts_pkg::seq_state_type state_ff, state_in;

   logic [can_bts_pkg::PRE_W-1:0]  pre_ff, pre_in;
   logic [can_bts_pkg::SUM_W-1:0]  sum_ff, sum_in;
   logic [can_bts_pkg::DIVR_W-1:0] divisor_ff, divisor_in;
   logic [can_bts_pkg::TGT_W-1:0]  target_ff, target_in;
   logic [can_bts_pkg::BND_W-1:0]  best_diff_ff, best_diff_in;
   logic [can_bts_pkg::PRE_W-1:0]  best_pre_ff, best_pre_in;
   logic [can_bts_pkg::SUM_W-1:0]  best_sum_ff, best_sum_in;
   logic [can_bts_pkg::RATE_W-1:0] win_rate_ff, win_rate_in;

   logic                           div_start, div_done;
   logic [can_bts_pkg::HALF_W-1:0] quotient, tgt_ext, diff;
   logic [can_bts_pkg::PROD_W-1:0] prod;
   logic                           better, exact, last_pair;

   can_bts_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (clk_hz[can_bts_pkg::CLK_W-1:1]),
      .divisor  (divisor_ff),
      .done     (div_done),
      .quotient (quotient)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= can_bts_pkg::SEQ_IDLE;
      end else begin
         state_ff <= state_in;
      end
      pre_ff       <= pre_in;
      sum_ff       <= sum_in;
      divisor_ff   <= divisor_in;
      target_ff    <= target_in;
      best_diff_ff <= best_diff_in;
      best_pre_ff  <= best_pre_in;
      best_sum_ff  <= best_sum_in;
      win_rate_ff  <= win_rate_in;
   end

   always_comb begin
      tgt_ext   = can_bts_pkg::HALF_W'(target_ff);
      diff      = (tgt_ext > quotient) ? tgt_ext - quotient : quotient - tgt_ext;
      better    = diff < can_bts_pkg::HALF_W'(best_diff_ff);
      exact     = (diff == '0);
      last_pair = (pre_ff == can_bts_pkg::PRE_W'(can_bts_pkg::MAX_PRESCALER)) &&
                  (sum_ff == can_bts_pkg::SUM_W'(can_bts_pkg::MAX_SEGMENT_SUM));
      prod      = can_bts_pkg::PROD_W'(pre_ff) * can_bts_pkg::PROD_W'(sum_ff + 1'b1);

      state_in     = state_ff;
      pre_in       = pre_ff;
      sum_in       = sum_ff;
      divisor_in   = divisor_ff;
      target_in    = target_ff;
      best_diff_in = best_diff_ff;
      best_pre_in  = best_pre_ff;
      best_sum_in  = best_sum_ff;
      win_rate_in  = win_rate_ff;
      div_start    = 1'b0;
      res.done     = 1'b0;

      unique case (state_ff)
         can_bts_pkg::SEQ_IDLE: begin
            if (go) begin
               target_in    = target;
               best_diff_in = clk_hz[can_bts_pkg::CLK_W-1:4];
               best_pre_in  = '0;
               best_sum_in  = '0;
               win_rate_in  = '0;
               pre_in       = can_bts_pkg::PRE_W'(1);
               sum_in       = can_bts_pkg::SUM_W'(can_bts_pkg::MIN_SEGMENT_SUM);
               state_in     = can_bts_pkg::SEQ_MUL;
            end
         end
         can_bts_pkg::SEQ_MUL: begin
            divisor_in = prod[can_bts_pkg::DIVR_W-1:0];
            state_in   = can_bts_pkg::SEQ_LOAD;
         end
         can_bts_pkg::SEQ_LOAD: begin
            div_start = 1'b1;
            state_in  = can_bts_pkg::SEQ_WAIT;
         end
         can_bts_pkg::SEQ_WAIT: begin
            if (div_done) begin
               state_in = can_bts_pkg::SEQ_EVAL;
            end
         end
         can_bts_pkg::SEQ_EVAL: begin
            if (better) begin
               best_diff_in = diff[can_bts_pkg::BND_W-1:0];
               best_pre_in  = pre_ff;
               best_sum_in  = sum_ff;
               win_rate_in  = quotient[can_bts_pkg::RATE_W-1:0];
            end
            // an exact hit ends the search even when it was not kept
            if (exact || last_pair) begin
               state_in = can_bts_pkg::SEQ_DONE;
            end else begin
               if (sum_ff == can_bts_pkg::SUM_W'(can_bts_pkg::MAX_SEGMENT_SUM)) begin
                  sum_in = can_bts_pkg::SUM_W'(can_bts_pkg::MIN_SEGMENT_SUM);
                  pre_in = pre_ff + 1'b1;
               end else begin
                  sum_in = sum_ff + 1'b1;
               end
               state_in = can_bts_pkg::SEQ_MUL;
            end
         end
         can_bts_pkg::SEQ_DONE: begin
            res.done = 1'b1;
            state_in = can_bts_pkg::SEQ_IDLE;
         end
         default: begin
            state_in = can_bts_pkg::SEQ_IDLE;
         end
      endcase

      res.pre  = best_pre_ff;
      res.sum  = best_sum_ff;
      res.rate = win_rate_ff;
   end

   a_bound_shrinks: assert property (@(posedge clock) disable iff (reset)
      (state_ff != can_bts_pkg::SEQ_IDLE) && ($past(state_ff) != can_bts_pkg::SEQ_IDLE)
      |-> best_diff_ff <= $past(best_diff_ff))
      else $error("best distance grew during a search");

   a_pre_range: assert property (@(posedge clock) disable iff (reset)
      res.done |-> res.pre <= can_bts_pkg::PRE_W'(can_bts_pkg::MAX_PRESCALER))
      else $error("prescaler beyond its range at search end");

endmodule
